// ----- rtl/fplw_pkg.sv -----
// ----------------------------------------------------------------------------
// fplw_pkg
// Types and constants shared by the four-level page walker modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fplw_pkg;

   // Physical address width of table entries and translated addresses.
   localparam int PHYS_BITS = 36;

   localparam int ADDR_BITS = 52;
   localparam int VA_BITS   = 48;
   localparam int TBASE_BITS = 36;

   localparam logic [ADDR_BITS-1:0] PHYS_MASK =
      ADDR_BITS'((64'd1 << PHYS_BITS) - 64'd1);
   localparam logic [ADDR_BITS-1:0] FRAME_4K = PHYS_MASK & ~ADDR_BITS'(64'hfff);
   localparam logic [ADDR_BITS-1:0] FRAME_2M = PHYS_MASK & ~ADDR_BITS'(64'h1f_ffff);
   localparam logic [ADDR_BITS-1:0] FRAME_1G = PHYS_MASK & ~ADDR_BITS'(64'h3fff_ffff);

   localparam logic OP_START    = 1'b0;
   localparam logic OP_RESPONSE = 1'b1;

   localparam logic KIND_READ = 1'b0;
   localparam logic KIND_DONE = 1'b1;

   // Level of the entry that the walk waits for.
   localparam logic [1:0] LVL_4 = 2'd0;
   localparam logic [1:0] LVL_3 = 2'd1;
   localparam logic [1:0] LVL_2 = 2'd2;
   localparam logic [1:0] LVL_1 = 2'd3;

   localparam int PRESENT_BIT = 0;
   localparam int SIZE_BIT    = 7;

   typedef struct packed {
      logic                  opcode;
      logic [TBASE_BITS-1:0] table_base;
      logic [VA_BITS-1:0]    virt_addr;
      logic [63:0]           mem_data;
   } req_type;

   typedef struct packed {
      logic                 result_kind;
      logic [ADDR_BITS-1:0] address;
      logic                 fault;
   } rsp_type;

   typedef struct packed {
      logic               busy;
      logic [1:0]         level;
      logic [VA_BITS-1:0] virt;
   } walk_state_type;

endpackage

`default_nettype wire

// ----- rtl/fplw_step.sv -----
// ----------------------------------------------------------------------------
// fplw_step
// One step of the page walk: from a beat and the walk state, the next state
// and the result beat, if any.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fplw_step (
   input  fplw_pkg::req_type        req,
   input  fplw_pkg::walk_state_type cur,
   output fplw_pkg::walk_state_type nxt,
   output logic                     emit,
   output fplw_pkg::rsp_type        rsp
);
   import fplw_pkg::*;

   function automatic logic [8:0] va_index(input logic [VA_BITS-1:0] va,
                                           input logic [1:0] lvl);
      logic [8:0] idx;
      case (lvl)
         LVL_4:   idx = va[47:39];
         LVL_3:   idx = va[38:30];
         LVL_2:   idx = va[29:21];
         LVL_1:   idx = va[20:12];
         default: idx = va[20:12];
      endcase
      return idx;
   endfunction

   logic [ADDR_BITS-1:0] base;
   logic [ADDR_BITS-1:0] entry;
   logic [ADDR_BITS-1:0] frame_4k;
   logic [ADDR_BITS-1:0] frame_2m;
   logic [ADDR_BITS-1:0] frame_1g;
   logic [1:0]           next_level;

   assign base       = {{(ADDR_BITS-TBASE_BITS){1'b0}}, req.table_base[TBASE_BITS-1:4],
                        4'b0};
   assign entry      = req.mem_data[ADDR_BITS-1:0];
   assign frame_4k   = entry & FRAME_4K;
   assign frame_2m   = entry & FRAME_2M;
   assign frame_1g   = entry & FRAME_1G;
   assign next_level = 2'(cur.level + 2'd1);

   always_comb begin
      nxt  = cur;
      emit = 1'b0;
      rsp  = '0;
      if (req.opcode == OP_START) begin
         nxt.busy        = 1'b1;
         nxt.level       = LVL_4;
         nxt.virt        = req.virt_addr;
         emit            = 1'b1;
         rsp.result_kind = KIND_READ;
         rsp.address     = (base + {40'b0, va_index(req.virt_addr, LVL_4), 3'b0})
                           & PHYS_MASK;
      end else if (cur.busy) begin
         emit = 1'b1;
         if (cur.level == LVL_1) begin
            nxt.busy        = 1'b0;
            nxt.level       = LVL_4;
            rsp.result_kind = KIND_DONE;
            if (frame_4k == '0) begin
               rsp.fault = 1'b1;
            end else begin
               rsp.address = (frame_4k + {40'b0, cur.virt[11:0]}) & PHYS_MASK;
            end
         end else if (!req.mem_data[PRESENT_BIT]) begin
            nxt.busy        = 1'b0;
            nxt.level       = LVL_4;
            rsp.result_kind = KIND_DONE;
            rsp.fault       = 1'b1;
         end else if (cur.level == LVL_3 && req.mem_data[SIZE_BIT]) begin
            nxt.busy        = 1'b0;
            nxt.level       = LVL_4;
            rsp.result_kind = KIND_DONE;
            rsp.address     = (frame_1g + {22'b0, cur.virt[29:0]}) & PHYS_MASK;
         end else if (cur.level == LVL_2 && req.mem_data[SIZE_BIT]) begin
            nxt.busy        = 1'b0;
            nxt.level       = LVL_4;
            rsp.result_kind = KIND_DONE;
            rsp.address     = (frame_2m + {31'b0, cur.virt[20:0]}) & PHYS_MASK;
         end else begin
            nxt.level       = next_level;
            rsp.result_kind = KIND_READ;
            rsp.address     = (frame_4k + {40'b0, va_index(cur.virt, next_level), 3'b0})
                              & PHYS_MASK;
         end
      end
   end

endmodule

`default_nettype wire

// ----- rtl/four_level_page_walker.sv -----
// ----------------------------------------------------------------------------
// four_level_page_walker
// An accepted beat passes the input register, then the combinational step
// logic, into the result register. Throughput: one beat per cycle while
// rsp_stall does not hold a full result register.
// Reset: synchronous; the walk returns to idle and both stages empty.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module four_level_page_walker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  fplw_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output fplw_pkg::rsp_type rsp_data
);
   import fplw_pkg::*;

   logic           in_valid_ff, in_valid_in;
   req_type        in_data_ff;
   walk_state_type state_ff;
   walk_state_type state_in;
   logic           out_valid_ff, out_valid_in;
   rsp_type        out_data_ff;
   logic           step_emit;
   rsp_type        step_rsp;
   logic           out_free;
   logic           advance;
   logic           accept;

   fplw_step u_step (
      .req  (in_data_ff),
      .cur  (state_ff),
      .nxt  (state_in),
      .emit (step_emit),
      .rsp  (step_rsp)
   );

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = step_emit;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   // Payload registers load only when their stage takes a new beat.
   always_ff @(posedge clock) begin
      if (accept) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         out_data_ff <= step_rsp;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

`default_nettype wire

// ----- tb/tb_four_level_page_walker.sv -----
// ----------------------------------------------------------------------------
// tb_four_level_page_walker
// Self-checking testbench for the four-level page walker. A short table of
// directed beats covers an idle drop, address wrap, faults at the first and
// last level, large pages and restarts. Random table walks follow. Every
// result beat is compared in order with the table or a walk-state predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_four_level_page_walker;

   import fplw_pkg::*;

   localparam int RANDOM_ITEMS = 1800;
   localparam int QUIET_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 16;

   typedef enum logic [1:0] {
      CHECK_MODEL,
      CHECK_NONE,
      CHECK_TYPED
   } check_mode_type;

   typedef struct {
      req_type        item;
      check_mode_type mode;
      rsp_type        typed_rsp;
   } walk_row_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   // Predicted walk state.
   logic               pw_busy  = 1'b0;
   logic [1:0]         pw_level = LVL_4;
   logic [VA_BITS-1:0] pw_virt  = '0;

   rsp_type      walk_results[$];
   walk_row_type walk_table[$];

   int req_idle_pct  = 25;
   int rsp_stall_pct = 25;
   int mismatches    = 0;
   int beats_sent    = 0;
   int reads_seen    = 0;
   int done_seen     = 0;
   int faults_seen   = 0;

   four_level_page_walker i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // Address of the 8-byte entry that the walk reads next for the given level.
   function automatic logic [ADDR_BITS-1:0] entry_address(input logic [ADDR_BITS-1:0] frame,
                                                        input logic [1:0] lvl);
      logic [8:0] idx;
      idx = pw_virt[39 - 9 * int'(lvl) +: 9];
      return (frame + ADDR_BITS'({idx, 3'b000})) & PHYS_MASK;
   endfunction

   function automatic bit walk_step(input req_type item, output rsp_type res);
      logic [ADDR_BITS-1:0] e;
      res = '0;
      if (item.opcode == OP_START) begin
         pw_virt  = item.virt_addr;
         pw_busy  = 1'b1;
         pw_level = LVL_4;
         res.result_kind = KIND_READ;
         res.address = entry_address(ADDR_BITS'({item.table_base[TBASE_BITS-1:4], 4'h0}),
                                     LVL_4);
         return 1'b1;
      end
      if (!pw_busy) return 1'b0;
      e = item.mem_data[ADDR_BITS-1:0];
      res.result_kind = KIND_DONE;
      // The last-level entry has no present test: only a zero frame faults.
      if (pw_level == LVL_1) begin
         if ((e & FRAME_4K) == '0) res.fault = 1'b1;
         else res.address = ((e & FRAME_4K) + ADDR_BITS'(pw_virt[11:0])) & PHYS_MASK;
      end else if (!item.mem_data[PRESENT_BIT]) begin
         res.fault = 1'b1;
      end else if (pw_level == LVL_3 && item.mem_data[SIZE_BIT]) begin
         res.address = ((e & FRAME_1G) + ADDR_BITS'(pw_virt[29:0])) & PHYS_MASK;
      end else if (pw_level == LVL_2 && item.mem_data[SIZE_BIT]) begin
         res.address = ((e & FRAME_2M) + ADDR_BITS'(pw_virt[20:0])) & PHYS_MASK;
      end else begin
         pw_level = pw_level + 2'd1;
         res.result_kind = KIND_READ;
         res.address = entry_address(e & FRAME_4K, pw_level);
         return 1'b1;
      end
      pw_busy  = 1'b0;
      pw_level = LVL_4;
      return 1'b1;
   endfunction

   task automatic add_row(input logic op, input logic [TBASE_BITS-1:0] base,
                          input logic [VA_BITS-1:0] va, input logic [63:0] data,
                          input check_mode_type mode, input rsp_type typed_rsp);
      walk_row_type row;
      row.item.opcode     = op;
      row.item.table_base = base;
      row.item.virt_addr  = va;
      row.item.mem_data   = data;
      row.mode            = mode;
      row.typed_rsp       = typed_rsp;
      walk_table.push_back(row);
   endtask

   function automatic req_type random_start();
      req_type     item;
      logic [63:0] r;
      r = rand64();
      item.opcode     = OP_START;
      item.table_base = r[TBASE_BITS-1:0];
      r = rand64();
      item.virt_addr  = r[VA_BITS-1:0];
      item.mem_data   = rand64();
      return item;
   endfunction

   // Mostly present entries so that walks get deep; size bits are common.
   function automatic req_type random_response(input logic [1:0] lvl);
      req_type     item;
      logic [63:0] r;
      logic [63:0] e;
      e = rand64();
      if (lvl == LVL_1) begin
         if ($urandom_range(0, 9) == 0) e = e & ~64'(FRAME_4K);
      end else begin
         e[PRESENT_BIT] = ($urandom_range(0, 99) < 92);
         e[SIZE_BIT]    = ($urandom_range(0, 99) < 30);
      end
      r = rand64();
      item.opcode     = OP_RESPONSE;
      item.table_base = r[TBASE_BITS-1:0];
      r = rand64();
      item.virt_addr  = r[VA_BITS-1:0];
      item.mem_data   = e;
      return item;
   endfunction

   // Called at a falling edge; returns at the falling edge after the beat.
   task automatic send_beat(input req_type item, input check_mode_type mode,
                            input rsp_type typed_rsp);
      rsp_type res;
      bit      has_result;
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      forever begin
         @(posedge clock);
         if (!req_stall) break;
      end
      has_result = walk_step(item, res);
      if (mode == CHECK_TYPED) walk_results.push_back(typed_rsp);
      else if (mode == CHECK_MODEL && has_result) walk_results.push_back(res);
      beats_sent++;
      @(negedge clock);
   endtask

   task automatic report_mismatch(input string what);
      mismatches++;
      $display("[%0t] mismatch: %s", $realtime, what);
   endtask

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < rsp_stall_pct);
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (walk_results.size() == 0) begin
            report_mismatch($sformatf("result beat with nothing expected: %h", rsp_data));
         end else begin
            want = walk_results.pop_front();
            if (rsp_data.result_kind !== want.result_kind)
               report_mismatch($sformatf("result_kind %b, expected %b",
                                         rsp_data.result_kind, want.result_kind));
            if (rsp_data.address !== want.address)
               report_mismatch($sformatf("address %h, expected %h",
                                         rsp_data.address, want.address));
            if (rsp_data.fault !== want.fault)
               report_mismatch($sformatf("fault %b, expected %b",
                                         rsp_data.fault, want.fault));
            if (want.fault) faults_seen++;
            else if (want.result_kind == KIND_DONE) done_seen++;
            else reads_seen++;
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
         else quiet++;
      end
      $display("FAIL four_level_page_walker");
      $finish;
   end

   initial begin : stimulus
      int  random_items;
      int  directed_items;
      bit  pressure_done;
      random_items  = 0;
      pressure_done = 1'b0;

      // Directed walks: idle drop, wrap of the first entry address, each
      // level reached, both large page sizes, a zero last-level frame and a
      // restart while busy.
      add_row(OP_RESPONSE, 36'h0, 48'h0, 64'hffff_ffff_ffff_ffff, CHECK_NONE, '0);
      add_row(OP_START, 36'hf_ffff_ffff, 48'hffff_ffff_ffff, 64'h0, CHECK_TYPED,
              {KIND_READ, 52'h0_0000_0000_0fe8, 1'b0});
      add_row(OP_RESPONSE, 36'h0, 48'h0, 64'h0, CHECK_TYPED, {KIND_DONE, 52'h0, 1'b1});
      add_row(OP_START, 36'h0, 48'h0, 64'hffff_ffff_ffff_ffff, CHECK_TYPED,
              {KIND_READ, 52'h0, 1'b0});
      add_row(OP_RESPONSE, 36'h0, 48'h0, 64'hffff_ffff_ffff_ffff, CHECK_MODEL, '0);
      add_row(OP_RESPONSE, 36'h0, 48'h0, 64'h0000_000f_ffff_f003, CHECK_MODEL, '0);
      add_row(OP_RESPONSE, 36'h0, 48'h0, 64'h8000_0000_1234_5001, CHECK_MODEL, '0);
      add_row(OP_RESPONSE, 36'h0, 48'h0, 64'hffff_ffff_ffff_fffe, CHECK_MODEL, '0);
      add_row(OP_START, 36'h1_2345_678f, 48'habcd_1234_5678, 64'h0, CHECK_MODEL, '0);
      add_row(OP_RESPONSE, 36'h0, 48'h0, 64'h0000_0000_0abc_d001, CHECK_MODEL, '0);
      add_row(OP_RESPONSE, 36'h0, 48'h0, 64'h8000_0000_4000_0081, CHECK_MODEL, '0);
      add_row(OP_START, 36'hf_0000_0000, 48'h7fff_ffff_ffff, 64'h0, CHECK_MODEL, '0);
      add_row(OP_RESPONSE, 36'h0, 48'h0, 64'h0000_000a_bcde_f0a1, CHECK_MODEL, '0);
      add_row(OP_RESPONSE, 36'h0, 48'h0, 64'h7ff0_0000_0000_0f01, CHECK_MODEL, '0);
      add_row(OP_RESPONSE, 36'h0, 48'h0, 64'h7fff_ffff_ffe0_0081, CHECK_MODEL, '0);
      add_row(OP_START, 36'h0_0000_0010, 48'h8000_0000_0000, 64'h0, CHECK_MODEL, '0);
      add_row(OP_RESPONSE, 36'h0, 48'h0, 64'h0000_0001_0000_0001, CHECK_MODEL, '0);
      add_row(OP_RESPONSE, 36'h0, 48'h0, 64'h0000_0002_0000_0003, CHECK_MODEL, '0);
      add_row(OP_RESPONSE, 36'h0, 48'h0, 64'h0000_0003_0000_0005, CHECK_MODEL, '0);
      add_row(OP_RESPONSE, 36'h0, 48'h0, 64'hffff_f000_0000_0fff, CHECK_TYPED,
              {KIND_DONE, 52'h0, 1'b1});
      add_row(OP_START, 36'ha_5a5a_5a50, 48'h0000_ffff_0000, 64'h0, CHECK_MODEL, '0);
      add_row(OP_RESPONSE, 36'h0, 48'h0, 64'h0000_0005_5555_5001, CHECK_MODEL, '0);
      add_row(OP_START, 36'h5_a5a5_a5af, 48'hffff_0000_ffff, 64'h0, CHECK_MODEL, '0);
      add_row(OP_RESPONSE, 36'h0, 48'h0, 64'hffff_ffff_ffff_fffe, CHECK_TYPED,
              {KIND_DONE, 52'h0, 1'b1});
      add_row(OP_RESPONSE, 36'h0, 48'h0, 64'h0, CHECK_NONE, '0);
      directed_items = walk_table.size();

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (walk_table[i]) begin
         send_beat(walk_table[i].item, walk_table[i].mode, walk_table[i].typed_rsp);
      end

      while (random_items < RANDOM_ITEMS) begin
         if (random_items >= 300 && random_items < 600) begin
            req_idle_pct  = 0;
            rsp_stall_pct = 0;
         end else begin
            req_idle_pct  = 25;
            rsp_stall_pct = 25;
         end
         // Once, hold the sender back until every expected result is in.
         if (!pressure_done && random_items >= RANDOM_ITEMS / 2) begin
            pressure_done = 1'b1;
            if (walk_results.size() != 0) begin
               req_valid <= 1'b0;
               while (walk_results.size() != 0) @(negedge clock);
            end
         end
         if ($urandom_range(0, 99) < 6) begin
            // A response with no walk in progress is dropped and not counted.
            if (pw_busy) random_items++;
            send_beat(random_response(pw_level), CHECK_MODEL, '0);
         end else begin
            send_beat(random_start(), CHECK_MODEL, '0);
            random_items++;
            // A walk left early is restarted by the next start beat.
            while (pw_busy && $urandom_range(0, 99) >= 4) begin
               send_beat(random_response(pw_level), CHECK_MODEL, '0);
               random_items++;
            end
         end
      end

      req_valid <= 1'b0;
      while (walk_results.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d request beats, %0d of them directed.", beats_sent, directed_items);
      $display("Checked %0d entry reads, %0d finished translations and %0d faults.",
               reads_seen, done_seen, faults_seen);
      if (mismatches == 0) begin
         $display("PASS four_level_page_walker");
      end else begin
         $display("FAIL four_level_page_walker");
      end
      $finish;
   end

endmodule

// ----- four_level_page_walker.f -----
rtl/fplw_pkg.sv
rtl/fplw_step.sv
rtl/four_level_page_walker.sv
tb/tb_four_level_page_walker.sv
